// File: hw/rtl/vector3_normalise_core_macros.svh
// Assertion macros shared by the vector normalize RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef VECTOR3_NORMALISE_CORE_MACROS_SVH
`define VECTOR3_NORMALISE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define VN3_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vn3 assertion failed");

// Check that cons holds in the cycle after ante
`define VN3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vn3 assertion failed");

`endif

// File: hw/rtl/vn3_pkg.sv
// Shared constants, state codes and helpers for the vector normalize core.
// No dependencies.
package vn3_pkg;

   localparam int COMP_W  = 32;   // input component width
   localparam int MAG_W   = 32;   // component magnitude width
   localparam int SUM_W   = 64;   // exact sum of squares
   localparam int ROOT_W  = 32;   // floor square root of the sum
   localparam int CMP_W   = 35;   // shared compare-subtract width
   localparam int QUOT_W  = 17;   // unsigned quotient bits
   localparam int OUT_W   = 18;   // signed result component
   localparam int CFG_W   = 16;   // min_length register
   localparam int CNT_W   = 5;
   localparam int IN_DATA_W  = 96;
   localparam int OUT_DATA_W = 56;

   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 17;

   localparam logic [OUT_W-1:0] ONE_Q16 = 18'h10000;

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] ST_SQUARE = 3'd1;
   localparam logic [STATE_W-1:0] ST_ROOT   = 3'd2;
   localparam logic [STATE_W-1:0] ST_DIVIDE = 3'd3;
   localparam logic [STATE_W-1:0] ST_FINISH = 3'd4;

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [OUT_W-1:0] res_type;

   // Magnitude of a two's complement word; the most negative value maps to 2^31
   function automatic mag_type magnitude(input logic [COMP_W-1:0] v);
      magnitude = v[COMP_W-1] ? mag_type'(~v + 1'b1) : mag_type'(v);
   endfunction

endpackage

// File: hw/rtl/vn3_cmpsub.sv
// Shared compare-subtract unit used by the square root and the divisions.
// Depends on vn3_pkg for the default width.
module vn3_cmpsub import vn3_pkg::*; #(
   parameter int WIDTH = CMP_W
) (
   input  logic [WIDTH-1:0] a_in,
   input  logic [WIDTH-1:0] b_in,
   output logic             ge,
   output logic [WIDTH-1:0] diff
);

   logic [WIDTH:0] full;

   // Subtract once; the borrow gives the compare
   assign full = {1'b0, a_in} - {1'b0, b_in};
   assign ge   = ~full[WIDTH];
   assign diff = full[WIDTH-1:0];

endmodule

// File: hw/rtl/vector3_normalise_core.sv
// Top level of the vector normalize core: sequencer, multiplier, output register.
// Depends on vn3_pkg, vn3_cmpsub and vector3_normalise_core_macros.svh.
//
//   port group  | dir | contents
//   req_*       | in  | tdata = x_in[31:0], y_in[63:32], z_in[95:64]
//   rsp_*       | out | tdata = x_out, y_out, z_out (18 bits each), tuser = fell_back
//   csr_*       | in  | csr_data = min_length[15:0], always ready
//
// The result word is loaded into the output register after the squares (one
// 32x32 multiplier and a 64-bit accumulator), 32 square root steps and 3 x 17
// division steps on the shared compare-subtract unit. A fallback vector skips
// the divisions. req_tready is high only when the sequencer is idle. A result
// stalled on rsp_tready holds the next vector in its last cycle. Reset is
// synchronous.
`include "vector3_normalise_core_macros.svh"
module vector3_normalise_core import vn3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // x_in, y_in, z_in from bit 0
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // x_out, y_out, z_out from bit 0, 2 pad
   output logic                  rsp_tuser,   // fell_back
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data     // min_length
);

   logic [STATE_W-1:0]    state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]            comp_ff, comp_in;
   mag_type               mag_ff [3];
   mag_type               mag_in [3];
   logic [2:0]            neg_ff, neg_in;
   logic [SUM_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CMP_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   res_type               res_ff [3];
   res_type               res_in [3];
   logic                  fallback_ff, fallback_in;
   logic [CFG_W-1:0]      min_length_ff, min_length_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   mag_type               mul_op;
   mag_type               div_mag;
   mag_type               next_mag;
   logic [CMP_W-1:0]      alu_a, alu_b, alu_diff;
   logic                  alu_ge;
   logic [ROOT_W-1:0]     root_fin;
   logic [QUOT_W-1:0]     quot_fin;
   res_type               quot_ext, res_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Select the multiplier operand by step
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mul_op = mag_ff[0];
         2'd1:    mul_op = mag_ff[1];
         2'd2:    mul_op = mag_ff[2];
         default: mul_op = '0;
      endcase
   end

   // Select the current and the next dividend magnitude
   always_comb begin
      case (comp_ff)
         2'd0: begin
            div_mag  = mag_ff[0];
            next_mag = mag_ff[1];
         end
         2'd1: begin
            div_mag  = mag_ff[1];
            next_mag = mag_ff[2];
         end
         2'd2: begin
            div_mag  = mag_ff[2];
            next_mag = '0;
         end
         default: begin
            div_mag  = '0;
            next_mag = '0;
         end
      endcase
   end

   // Feed the shared unit: root trial in ROOT, divisor compare otherwise
   always_comb begin
      if (state_ff == ST_ROOT) begin
         alu_a = {rem_ff[CMP_W-3:0], sum_ff[SUM_W-1:SUM_W-2]};
         alu_b = {1'b0, root_ff, 2'b01};
      end else begin
         alu_a = (cnt_ff == '0) ? rem_ff : {rem_ff[CMP_W-2:0], 1'b0};
         alu_b = {{(CMP_W-ROOT_W){1'b0}}, root_ff};
      end
   end

   vn3_cmpsub #(.WIDTH(CMP_W)) u_cmpsub (
      .a_in (alu_a),
      .b_in (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   assign root_fin = {root_ff[ROOT_W-2:0], alu_ge};
   assign quot_fin = {quot_ff[QUOT_W-2:0], alu_ge};
   assign quot_ext = {1'b0, quot_fin};
   assign res_val  = neg_ff[comp_ff] ? res_type'(~quot_ext + 1'b1) : quot_ext;

   // Sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      comp_in       = comp_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prod_in       = SUM_W'(mul_op) * SUM_W'(mul_op);
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      quot_in       = quot_ff;
      res_in        = res_ff;
      fallback_in   = fallback_ff;
      min_length_in = min_length_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_valid) begin
         min_length_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mag_in[0] = magnitude(req_tdata[31:0]);
               mag_in[1] = magnitude(req_tdata[63:32]);
               mag_in[2] = magnitude(req_tdata[95:64]);
               neg_in    = {req_tdata[95], req_tdata[63], req_tdata[31]};
               cnt_in    = '0;
               sum_in    = '0;
               rem_in    = '0;
               root_in   = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // Accumulate the registered product of the previous component
            if (cnt_ff != '0) begin
               sum_in = sum_ff + prod_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // One root bit a step, two sum bits shifted in
            rem_in  = alu_ge ? alu_diff : alu_a;
            root_in = root_fin;
            sum_in  = {sum_ff[SUM_W-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               cnt_in  = '0;
               comp_in = '0;
               quot_in = '0;
               rem_in  = {{(CMP_W-MAG_W){1'b0}}, mag_ff[0]};
               if (root_fin <= {{(ROOT_W-CFG_W){1'b0}}, min_length_ff}) begin
                  fallback_in = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  fallback_in = 1'b0;
                  state_in    = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            // One quotient bit a step, restoring
            rem_in  = alu_ge ? alu_diff : alu_a;
            quot_in = quot_fin;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               case (comp_ff)
                  2'd0:    res_in[0] = res_val;
                  2'd1:    res_in[1] = res_val;
                  default: res_in[2] = res_val;
               endcase
               cnt_in  = '0;
               quot_in = '0;
               rem_in  = {{(CMP_W-MAG_W){1'b0}}, next_mag};
               comp_in = comp_ff + 1'b1;
               if (comp_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = fallback_ff;
               if (fallback_ff) begin
                  rsp_data_in = {2'b00, {(2*OUT_W){1'b0}}, ONE_Q16};
               end else begin
                  rsp_data_in = {2'b00, res_ff[2], res_ff[1], res_ff[0]};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers: control cleared by reset, payload free running
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         min_length_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_length_ff <= min_length_in;
      end
      cnt_ff      <= cnt_in;
      comp_ff     <= comp_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      quot_ff     <= quot_in;
      res_ff      <= res_in;
      fallback_ff <= fallback_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Checks
   `VN3_ASSERT_NOW(fallback_word_is_unit_x, rsp_tvalid && rsp_tuser,
      rsp_tdata[17:0] == ONE_Q16 && rsp_tdata[53:18] == '0)
   `VN3_ASSERT_NEXT(accept_starts_squares, req_tvalid && req_tready,
      state_ff == ST_SQUARE && cnt_ff == '0)
   `VN3_ASSERT_NOW(divide_rem_below_divisor, state_ff == ST_DIVIDE,
      rem_ff[CMP_W-1:ROOT_W] == '0 && rem_ff[ROOT_W-1:0] <= root_ff)
   `VN3_ASSERT_NOW(x_out_in_unit_range, rsp_tvalid && !rsp_tuser,
      rsp_tdata[17] == rsp_tdata[16] || rsp_tdata[15:0] == '0)

endmodule

// File: test/vector3_normalise_core_tb.sv
// Self-checking testbench for vector3_normalise_core: unit vectors of signed Q16.16 triples.
// Drives directed and random vectors and checks every result word against a local model.
// Depends on vn3_pkg and the vector3_normalise_core RTL.
module vector3_normalise_core_tb import vn3_pkg::*; ();

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_GAP        = 18;
   localparam int SETTLE_CYCLES  = 120;     // a little over one vector's latency
   localparam int LONG_HOLD      = 400;     // receiver hold-off in the pressure test
   localparam int PHASE_ITEMS    = 120;
   localparam int TIMEOUT_CYCLES = 600_000;

   typedef struct packed {
      res_type x;
      res_type y;
      res_type z;
      logic    fell_back;
   } unit_vec_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata;    // x_in, y_in, z_in from bit 0
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;    // x_out, y_out, z_out from bit 0, 2 pad
   logic                  rsp_tuser;    // fell_back
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data;     // min_length

   unit_vec_type     unit_expected[$];
   logic [CFG_W-1:0] min_length_cfg = '0;
   int unsigned      fail_count = 0;
   bit               no_idle = 1'b0;
   int unsigned      sink_hold = 0;

   vector3_normalise_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Floor of the square root of a 64-bit value, one result bit per pass
   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_w;
      rem   = n;
      root  = '0;
      bit_w = 64'h1 << 62;
      while (bit_w > rem)
         bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem  = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] abs_component(input logic [COMP_W-1:0] c);
      logic [COMP_W-1:0] m;
      m = c[COMP_W-1] ? (~c + 32'd1) : c;
      return {32'd0, m};
   endfunction

   // Component scaled to unit length, truncated toward zero
   function automatic res_type unit_component(input logic [COMP_W-1:0] c,
                                              input logic [63:0] len);
      logic [63:0] q;
      q = (abs_component(c) << 16) / len;
      if (c[COMP_W-1])
         q = ~q + 64'd1;
      return q[OUT_W-1:0];
   endfunction

   function automatic unit_vec_type predict_unit(input logic [COMP_W-1:0] x,
                                                 input logic [COMP_W-1:0] y,
                                                 input logic [COMP_W-1:0] z);
      logic [63:0]  mx;
      logic [63:0]  my;
      logic [63:0]  mz;
      logic [63:0]  len;
      unit_vec_type r;
      mx  = abs_component(x);
      my  = abs_component(y);
      mz  = abs_component(z);
      len = floor_sqrt(mx * mx + my * my + mz * mz);
      if (len <= {48'd0, min_length_cfg}) begin
         r.x = ONE_Q16;
         r.y = '0;
         r.z = '0;
         r.fell_back = 1'b1;
      end else begin
         r.x = unit_component(x, len);
         r.y = unit_component(y, len);
         r.z = unit_component(z, len);
         r.fell_back = 1'b0;
      end
      return r;
   endfunction

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Mix of zeros, extremes, full-range, scaled-down and near-threshold values
   function automatic logic [COMP_W-1:0] rand_component();
      logic [COMP_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2, 3: v = $urandom;
         4, 5: v = $urandom >> $urandom_range(8, 31);
         default: v = $urandom_range(0, 2 * int'(min_length_cfg) + 4);
      endcase
      if (v[COMP_W-1] == 1'b0 && $urandom_range(0, 1))
         v = ~v + 32'd1;
      return v;
   endfunction

   // Offer one vector after a random gap; record the prediction on accept
   task automatic send_vector(input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                              input logic [COMP_W-1:0] z);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      unit_expected.push_back(predict_unit(x, y, z));
      @(negedge clock);
   endtask

   // Drop the request and wait until every expected word has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (unit_expected.size() != 0);
   endtask

   task automatic write_min_length(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      min_length_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         fail_count++;
      end
   endtask

   // Extremes of the components, zero vector, 2D vector, most negative values
   task automatic test_extremes();
      send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vector(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
      send_vector(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_vector(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_vector(32'h0003_0000, 32'hFFFC_0000, 32'h0000_0000);
      send_vector(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      drain_results();
   endtask

   // Lengths on and just past the fallback threshold, low and high settings
   task automatic test_threshold();
      write_min_length(16'd100);
      send_vector(32'd100, 32'd0, 32'd0);
      send_vector(32'd101, 32'd0, 32'd0);
      send_vector(32'd60, -32'sd80, 32'd0);
      send_vector(32'd0, 32'd0, -32'sd101);
      drain_results();
      write_min_length(16'hFFFF);
      send_vector(32'h0000_FFFF, 32'd0, 32'd0);
      send_vector(32'h0001_0000, 32'd0, 32'd0);
      send_vector(32'd0, 32'hFFFF_0000, 32'd0);
      send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      drain_results();
   endtask

   // Stall the result side for a long stretch while vectors keep coming
   task automatic test_backpressure();
      write_min_length(16'd0);
      sink_hold = LONG_HOLD;
      no_idle   = 1'b1;
      repeat (6)
         send_vector(rand_component(), rand_component(), rand_component());
      drain_results();
      no_idle = 1'b0;
   endtask

   // Random vectors over several threshold settings
   task automatic test_random();
      logic [CFG_W-1:0] setting;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       setting = 16'd0;
            1:       setting = 16'hFFFF;
            2:       setting = 16'd1;
            3:       setting = 16'($urandom_range(0, 255));
            default: setting = 16'($urandom);
         endcase
         write_min_length(setting);
         no_idle = (p == 4);
         repeat (PHASE_ITEMS)
            send_vector(rand_component(), rand_component(), rand_component());
         drain_results();
      end
      no_idle = 1'b0;
   endtask

   // Result side: random stall per word, or the long hold when requested
   initial begin : result_sink
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (sink_hold != 0) begin
            stall     = sink_hold;
            sink_hold = 0;
         end else begin
            stall = draw_gap();
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (unit_expected.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h/%b",
                     $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = unit_expected.pop_front();
            check_field("x_out", int'($signed(want.x)), int'($signed(rsp_tdata[17:0])));
            check_field("y_out", int'($signed(want.y)), int'($signed(rsp_tdata[35:18])));
            check_field("z_out", int'($signed(want.z)), int'($signed(rsp_tdata[53:36])));
            check_field("fell_back", int'(want.fell_back), int'(rsp_tuser));
         end
      end
   end

   initial begin : run_limit
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("** vector3_normalise_core: FAILED **");
      $finish;
   end

   initial begin : test_sequence
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes();
      test_threshold();
      test_backpressure();
      test_random();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** vector3_normalise_core: PASSED **");
      end else begin
         $display("** vector3_normalise_core: FAILED **");
      end
      $finish;
   end

endmodule
